// ===== src/ure_pkg.sv =====
// Shared constants and types for the ultrasonic echo ranger.
package ure_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int TIME_W   = 8;
  localparam int DIST_W   = 16;
  localparam int BAND_W   = 3;
  localparam int THOUS_W  = 6;
  localparam int DIGIT_W  = 4;
  localparam int NUM_BANDS = 5;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_2ND   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_3RD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_4TH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_5TH   = 3'd7;

  // Decimal form of a distance: thousands kept binary (0..44)
  typedef struct packed {
    logic [THOUS_W-1:0] thousands;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } dec_dist_t;

endpackage

// ===== src/ure_in_if.sv =====
// Input channel: one tick with start request and echo level.
interface ure_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic echo_level;

  modport source (output valid, output start_request, output echo_level, input ready);
  modport sink   (input valid, input start_request, input echo_level, output ready);
endinterface

// ===== src/ure_out_if.sv =====
// Result channel: trigger, status and the latched distance in several forms.
interface ure_out_if import ure_pkg::*;;
  logic               valid;
  logic               ready;
  logic               trigger_level;
  logic               busy_res;
  logic               done_res;
  logic [DIST_W-1:0]  distance_mm;
  logic [BAND_W-1:0]  band;
  logic [THOUS_W-1:0] digit_thousands;
  logic [DIGIT_W-1:0] digit_hundreds;
  logic [DIGIT_W-1:0] digit_tens;
  logic [DIGIT_W-1:0] digit_ones;

  modport source (output valid, output trigger_level, output busy_res, output done_res,
                  output distance_mm, output band, output digit_thousands,
                  output digit_hundreds, output digit_tens, output digit_ones,
                  input ready);
  modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                  input distance_mm, input band, input digit_thousands,
                  input digit_hundreds, input digit_tens, input digit_ones,
                  output ready);
endinterface

// ===== src/ultrasonic_echo_ranger.sv =====
// A result is in the output register in the cycle after its input transfer.
// Throughput: one tick per cycle; the input is taken while a result waits, as long
// as the output register is empty or drained in the same cycle.
// Distance and decimal digits are tracked incrementally (17/25 per count), so no divider.
// Reset: async active low; idle phase, counters and latched distance zero,
// configuration at its defaults, output register empty.
module ultrasonic_echo_ranger import ure_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ure_in_if.sink                in_i,
  ure_out_if.source             out_o
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LOW   = 3'd1;
  localparam logic [2:0] PH_HIGH  = 3'd2;
  localparam logic [2:0] PH_WAIT  = 3'd3;
  localparam logic [2:0] PH_COUNT = 3'd4;

  localparam int          REM_W   = 5;
  localparam logic [5:0]  DIST_NUM = 6'd17;  // 680/1000 = 17/25
  localparam logic [5:0]  DIST_DEN = 6'd25;
  localparam logic [32:0] CNT_CLAMP = 33'd65535;

  // configuration
  logic [TIME_W-1:0] trig_low_q, trig_high_q, period_q;
  logic [DIST_W-1:0] limit_q [NUM_BANDS];

  // measurement state
  logic [2:0]             phase_q, phase_d;
  logic [TIME_W-1:0]      timer_q, timer_d;
  logic [TIME_W-1:0]      pre_q, pre_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [DIST_W-1:0]      dist_q, dist_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  dec_dist_t              dec_q, dec_d;
  logic [DIST_W-1:0]      last_q, last_d;
  dec_dist_t              last_dec_q, last_dec_d;

  // result register
  logic               out_valid_q;
  logic               trig_res, busy_res, done_res;
  logic [BAND_W-1:0]  band_res;
  logic               accept;

  function automatic dec_dist_t dec_inc(dec_dist_t v);
    dec_dist_t r;
    r = v;
    if (v.ones != 4'd9) begin
      r.ones = v.ones + 4'd1;
    end else begin
      r.ones = '0;
      if (v.tens != 4'd9) begin
        r.tens = v.tens + 4'd1;
      end else begin
        r.tens = '0;
        if (v.hundreds != 4'd9) begin
          r.hundreds = v.hundreds + 4'd1;
        end else begin
          r.hundreds  = '0;
          r.thousands = v.thousands + 6'd1;
        end
      end
    end
    return r;
  endfunction

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_low_q  <= 8'd10;
      trig_high_q <= 8'd10;
      period_q    <= 8'd4;
      limit_q[0]  <= 16'd30;
      limit_q[1]  <= 16'd70;
      limit_q[2]  <= 16'd100;
      limit_q[3]  <= 16'd130;
      limit_q[4]  <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRIG_LOW:   trig_low_q  <= cfg_data_i[TIME_W-1:0];
        REG_TRIG_HIGH:  trig_high_q <= cfg_data_i[TIME_W-1:0];
        REG_PERIOD:     period_q    <= cfg_data_i[TIME_W-1:0];
        REG_BAND_FIRST: limit_q[0]  <= cfg_data_i;
        REG_BAND_2ND:   limit_q[1]  <= cfg_data_i;
        REG_BAND_3RD:   limit_q[2]  <= cfg_data_i;
        REG_BAND_4TH:   limit_q[3]  <= cfg_data_i;
        REG_BAND_5TH:   limit_q[4]  <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    logic              tick;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] pre_inc;
    logic [5:0]        rem_sum;

    phase_d    = phase_q;
    timer_d    = timer_q;
    pre_d      = pre_q;
    count_d    = count_q;
    dist_d     = dist_q;
    rem_d      = rem_q;
    dec_d      = dec_q;
    last_d     = last_q;
    last_dec_d = last_dec_q;
    trig_res   = 1'b0;
    busy_res   = 1'b1;
    done_res   = 1'b0;
    tick       = 1'b0;
    per        = (period_q == '0) ? 8'd1 : period_q;
    pre_inc    = '0;
    rem_sum    = '0;

    if (phase_d == PH_IDLE) begin
      if (in_i.start_request) begin
        phase_d = PH_LOW;
        timer_d = trig_low_q;
      end else begin
        busy_res = 1'b0;
      end
    end else begin
      // low time can run out and fall through into the pulse on the same tick
      if (phase_d == PH_LOW) begin
        if (timer_d == '0) begin
          phase_d = PH_HIGH;
          timer_d = trig_high_q;
        end else begin
          timer_d = timer_d - 8'd1;
        end
      end
      if (phase_d == PH_HIGH) begin
        if (timer_d == '0) begin
          phase_d = PH_WAIT;
        end else begin
          trig_res = 1'b1;
          timer_d  = timer_d - 8'd1;
        end
      end
      if (phase_d == PH_WAIT) begin
        if (in_i.echo_level) begin
          phase_d = PH_COUNT;
          count_d = '0;
          pre_d   = '0;
          dist_d  = '0;
          rem_d   = '0;
          dec_d   = '0;
          tick    = 1'b1;
        end
      end else if (phase_d == PH_COUNT) begin
        if (in_i.echo_level) begin
          tick = 1'b1;
        end else begin
          last_d     = dist_d;
          last_dec_d = dec_d;
          done_res   = 1'b1;
          busy_res   = 1'b0;
          phase_d    = PH_IDLE;
          timer_d    = '0;
        end
      end else if (phase_d > PH_COUNT) begin
        phase_d  = PH_IDLE;
        busy_res = 1'b0;
      end
    end

    if (tick) begin
      pre_inc = pre_d + 8'd1;
      if (pre_inc >= per) begin
        pre_d = '0;
        if (count_d != '1) begin
          // distance follows min(count, 65535): floor(17*count/25)
          if (33'(count_d) < CNT_CLAMP) begin
            rem_sum = {1'b0, rem_d} + DIST_NUM;
            if (rem_sum >= DIST_DEN) begin
              rem_d  = REM_W'(rem_sum - DIST_DEN);
              dist_d = dist_d + 16'd1;
              dec_d  = dec_inc(dec_d);
            end else begin
              rem_d = REM_W'(rem_sum);
            end
          end
          count_d = count_d + COUNT_WIDTH'(1);
        end
      end else begin
        pre_d = pre_inc;
      end
    end
  end

  always_comb begin
    priority if (last_d <= limit_q[0]) band_res = 3'd0;
    else if (last_d <= limit_q[1])     band_res = 3'd1;
    else if (last_d <= limit_q[2])     band_res = 3'd2;
    else if (last_d <= limit_q[3])     band_res = 3'd3;
    else if (last_d <= limit_q[4])     band_res = 3'd4;
    else                               band_res = 3'd5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      timer_q    <= '0;
      pre_q      <= '0;
      count_q    <= '0;
      dist_q     <= '0;
      rem_q      <= '0;
      dec_q      <= '0;
      last_q     <= '0;
      last_dec_q <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      pre_q      <= pre_d;
      count_q    <= count_d;
      dist_q     <= dist_d;
      rem_q      <= rem_d;
      dec_q      <= dec_d;
      last_q     <= last_d;
      last_dec_q <= last_dec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_o.trigger_level   <= trig_res;
      out_o.busy_res        <= busy_res;
      out_o.done_res        <= done_res;
      out_o.distance_mm     <= last_d;
      out_o.band            <= band_res;
      out_o.digit_thousands <= last_dec_d.thousands;
      out_o.digit_hundreds  <= last_dec_d.hundreds;
      out_o.digit_tens      <= last_dec_d.tens;
      out_o.digit_ones      <= last_dec_d.ones;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < REM_W'(DIST_DEN))
    else $error("distance remainder out of range");

  a_done_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done_res) |=> (last_q == $past(dist_q)))
    else $error("latched distance does not match accumulator");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_o.done_res && out_o.busy_res))
    else $error("done and busy both set");

  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.trigger_level) |-> out_o.busy_res)
    else $error("trigger driven while not busy");

  a_idle_count_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE && $past(phase_q) == PH_IDLE) |-> $stable(last_q))
    else $error("latched distance changed while idle");
`endif

endmodule
